@@ rtl/time_sorted_event_queue_defines.svh @@
// ----------------------------------------------------------------------------
// time_sorted_event_queue_defines
// Assertion macros used by the checker file, tseq_checker.
// ----------------------------------------------------------------------------
`ifndef TIME_SORTED_EVENT_QUEUE_DEFINES_SVH
`define TIME_SORTED_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TSEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tseq assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define TSEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tseq assertion failed");

`endif

@@ rtl/tseq_pkg.sv @@
// ----------------------------------------------------------------------------
// tseq_pkg
// Types and constants of the time-sorted event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tseq_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int TIME_BITS    = 32;
  localparam int PAYLOAD_BITS = 16;
  localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_POP     = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic  load;
    logic  insert;
    logic  shift;
    logic  emit;
    stat_t emit_status;
    logic  emit_entry;
    logic  emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic due0;
    logic due1;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/tseq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tseq_ctrl
// Request sequencer: takes a request, then drives insert, pop or the
// release run one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tseq_ctrl
  import tseq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_kind,
  input  wire dp_status_t sts,
  output dp_cmd_t         cmd,
  output logic            busy
);

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_INSERT;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    busy      = 1'b1;
    cmd       = '0;
    cmd.emit_status = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          kind_nxt  = kind_t'(in_kind);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (kind_r)
          KIND_INSERT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.insert    = !sts.full;
            cmd.emit_status = sts.full ? STAT_FULL : STAT_OK;
          end
          KIND_POP: begin
            cmd.emit       = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_entry = !sts.empty;
            cmd.shift      = !sts.empty;
            cmd.emit_status = sts.empty ? STAT_EMPTY : STAT_OK;
          end
          KIND_RELEASE: begin
            cmd.emit = 1'b1;
            if (!sts.due0) begin
              cmd.emit_last   = 1'b1;
              cmd.emit_status = STAT_EMPTY;
            end else begin
              cmd.emit_entry = 1'b1;
              cmd.shift      = 1'b1;
              cmd.emit_last  = !sts.due1;
              if (sts.due1) state_nxt = S_EXEC;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tseq_datapath.sv @@
// ----------------------------------------------------------------------------
// tseq_datapath
// Sorted row of entry cells with parallel compare, entry count, request
// operand registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tseq_datapath
  import tseq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [TIME_BITS-1:0]    in_time_stamp,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  input  wire dp_cmd_t                 cmd,
  output dp_status_t                   sts,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [TIME_BITS-1:0]         out_time,
  output logic [PAYLOAD_BITS-1:0]      out_payload,
  output logic                         out_last
);

  logic [TIME_BITS-1:0]    etime_r [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] epay_r  [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]     count_r;
  logic [TIME_BITS-1:0]    key_r;
  logic [PAYLOAD_BITS-1:0] note_r;
  logic [QUEUE_DEPTH-1:0]  valid;
  logic [QUEUE_DEPTH-1:0]  lt;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [TIME_BITS-1:0]    out_time_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  logic                    out_last_r;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid[i] = CNT_BITS'(i) < count_r;
      lt[i]    = valid[i] && (etime_r[i] < key_r);
    end
  end

  assign sts.full  = count_r == CNT_BITS'(QUEUE_DEPTH);
  assign sts.empty = count_r == '0;
  assign sts.due0  = valid[0] && (etime_r[0] <= key_r);
  assign sts.due1  = valid[1] && (etime_r[1] <= key_r);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [TIME_BITS-1:0]    up_time;
    logic [PAYLOAD_BITS-1:0] up_pay;
    logic [TIME_BITS-1:0]    dn_time;
    logic [PAYLOAD_BITS-1:0] dn_pay;
    logic                    take_new;

    if (g == 0) begin : g_head
      assign dn_time  = key_r;
      assign dn_pay   = note_r;
      assign take_new = !lt[0];
    end else begin : g_body
      assign dn_time  = etime_r[g-1];
      assign dn_pay   = epay_r[g-1];
      assign take_new = !lt[g] && lt[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign up_time = etime_r[g];
      assign up_pay  = epay_r[g];
    end else begin : g_mid
      assign up_time = etime_r[g+1];
      assign up_pay  = epay_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && !lt[g]) begin
        etime_r[g] <= take_new ? key_r  : dn_time;
        epay_r[g]  <= take_new ? note_r : dn_pay;
      end else if (cmd.shift) begin
        etime_r[g] <= up_time;
        epay_r[g]  <= up_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.insert) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (cmd.shift) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_time_stamp;
      note_r <= in_payload;
    end
    if (cmd.emit) begin
      out_status_r  <= cmd.emit_status;
      out_time_r    <= cmd.emit_entry ? etime_r[0] : '0;
      out_payload_r <= cmd.emit_entry ? epay_r[0] : '0;
      out_last_r    <= cmd.emit_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_time    = out_time_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

@@ rtl/time_sorted_event_queue.sv @@
// The first result is registered from the execute phase; release results then follow 1 per cycle.
// A request is accepted in the idle phase and served in the execute phase; a release repeats that phase
// for each due entry leaving the cell row. Busy stays high outside idle, so no new request is taken then.
// Results are a one-cycle strobe on out_valid; the receiver cannot stall them.
// Synchronous active-low reset empties the queue at once; entry cells are not cleared.
// ----------------------------------------------------------------------------
// time_sorted_event_queue
// Bounded queue of timed entries kept in ascending time order, with insert,
// pop earliest and release of all entries due up to a given time.
// ----------------------------------------------------------------------------
`default_nettype none

module time_sorted_event_queue
  import tseq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_kind,
  input  wire logic [TIME_BITS-1:0]    in_time_stamp,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [TIME_BITS-1:0]         out_time,
  output logic [PAYLOAD_BITS-1:0]      out_payload,
  output logic                         out_last
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  tseq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  tseq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_time_stamp (in_time_stamp),
    .in_payload    (in_payload),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_time      (out_time),
    .out_payload   (out_payload),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/tseq_checker.sv @@
// ----------------------------------------------------------------------------
// tseq_checker
// Port-level checks of request and result timing for the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "time_sorted_event_queue_defines.svh"

module tseq_checker
  import tseq_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    out_valid,
  input wire logic [1:0]              out_status,
  input wire logic [TIME_BITS-1:0]    out_time,
  input wire logic [PAYLOAD_BITS-1:0] out_payload,
  input wire logic                    out_last
);

  `TSEQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `TSEQ_ASSERT_NEXT(a_run_continues, out_valid && !out_last, out_valid)
  `TSEQ_ASSERT_NEXT(a_gap_after_last, out_valid && out_last, !out_valid)
  `TSEQ_ASSERT_NOW(a_no_entry_zero, out_valid && out_status != STAT_OK, out_time == '0 && out_payload == '0)

endmodule

bind time_sorted_event_queue tseq_checker u_tseq_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time-sorted event queue. A directed opening
// covers empty, none-due, equal-time and extreme-time cases. A random part
// then runs inserts, pops, releases, fill-to-full bursts and unused kinds.
// A scoreboard keeps its own sorted copy of the queue and checks every
// result strobe in order.
// ----------------------------------------------------------------------------

module tb_top;
  import tseq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 420;

  typedef struct packed {
    stat_t                   status;
    logic [TIME_BITS-1:0]    ev_time;
    logic [PAYLOAD_BITS-1:0] ev_payload;
    logic                    last;
  } queued_result_t;

  class event_queue_scoreboard;
    logic [TIME_BITS-1:0]    slot_time    [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] slot_payload [QUEUE_DEPTH];
    int unsigned             fill;
    queued_result_t          pending [$];
    int unsigned             errors;
    int unsigned             requests_seen;
    int unsigned             results_seen;
    int unsigned             full_drops;
    int unsigned             empty_hits;
    int unsigned             longest_release;

    function new();
      fill = 0;
      errors = 0;
      requests_seen = 0;
      results_seen = 0;
      full_drops = 0;
      empty_hits = 0;
      longest_release = 0;
    endfunction

    function void drop_front(int unsigned n);
      for (int i = 0; i + n < fill; i++) begin
        slot_time[i]    = slot_time[i + n];
        slot_payload[i] = slot_payload[i + n];
      end
      fill = (n >= fill) ? 0 : fill - n;
    endfunction

    function void push_result(stat_t st, logic [TIME_BITS-1:0] t,
                              logic [PAYLOAD_BITS-1:0] pl, logic lst);
      queued_result_t r;
      r.status     = st;
      r.ev_time    = t;
      r.ev_payload = pl;
      r.last       = lst;
      pending = {pending, r};
    endfunction

    function void note_request(logic [1:0] kind, logic [TIME_BITS-1:0] ts,
                               logic [PAYLOAD_BITS-1:0] pl);
      int unsigned pos;
      int unsigned due;
      requests_seen++;
      case (kind)
        KIND_INSERT: begin
          if (fill >= QUEUE_DEPTH) begin
            full_drops++;
            push_result(STAT_FULL, '0, '0, 1'b1);
          end else begin
            pos = 0;
            while (pos < fill && slot_time[pos] < ts) pos++;
            for (int i = fill; i > pos; i--) begin
              slot_time[i]    = slot_time[i - 1];
              slot_payload[i] = slot_payload[i - 1];
            end
            slot_time[pos]    = ts;
            slot_payload[pos] = pl;
            fill++;
            push_result(STAT_OK, '0, '0, 1'b1);
          end
        end
        KIND_POP: begin
          if (fill == 0) begin
            empty_hits++;
            push_result(STAT_EMPTY, '0, '0, 1'b1);
          end else begin
            push_result(STAT_OK, slot_time[0], slot_payload[0], 1'b1);
            drop_front(1);
          end
        end
        KIND_RELEASE: begin
          due = 0;
          while (due < fill && slot_time[due] <= ts) due++;
          if (due == 0) begin
            empty_hits++;
            push_result(STAT_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < due; i++)
              push_result(STAT_OK, slot_time[i], slot_payload[i], (i + 1 == due));
            if (due > longest_release) longest_release = due;
            drop_front(due);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic [TIME_BITS-1:0] t,
                               logic [PAYLOAD_BITS-1:0] pl, logic lst);
      queued_result_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d time %0h payload %0h last %0b",
                 $time, st, t, pl, lst);
        return;
      end
      exp = pending.pop_front();
      if (st !== exp.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status, st);
      end
      if (t !== exp.ev_time) begin
        errors++;
        $display("%0t: out_time mismatch, expected %0h, got %0h", $time, exp.ev_time, t);
      end
      if (pl !== exp.ev_payload) begin
        errors++;
        $display("%0t: out_payload mismatch, expected %0h, got %0h",
                 $time, exp.ev_payload, pl);
      end
      if (lst !== exp.last) begin
        errors++;
        $display("%0t: out_last mismatch, expected %0b, got %0b", $time, exp.last, lst);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_kind;
  logic [TIME_BITS-1:0]    in_time_stamp;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic [TIME_BITS-1:0]    out_time;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    out_last;

  event_queue_scoreboard sb;
  int unsigned           random_sent;
  bit                    quiet;

  time_sorted_event_queue dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_time_stamp(in_time_stamp),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_time     (out_time),
    .out_payload  (out_payload),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_time, out_payload, out_last);
  end

  task automatic send_request(input logic [1:0] kind, input logic [TIME_BITS-1:0] ts,
                              input logic [PAYLOAD_BITS-1:0] pl);
    @(negedge clk);
    start         = 1'b1;
    in_kind       = kind;
    in_time_stamp = ts;
    in_payload    = pl;
    do @(posedge clk); while (busy);
    sb.note_request(kind, ts, pl);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start         = 1'b0;
      in_kind       = 2'($urandom);
      in_time_stamp = $urandom;
      in_payload    = 16'($urandom);
    end
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 99) < 6) idle_cycles($urandom_range(1, 4));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TIME_BITS-1:0] pick_time();
    logic [TIME_BITS-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = '0;
      1:       t = '1;
      2, 3, 4: t = $urandom_range(0, 63);
      5, 6: begin
        if (sb.fill > 0) t = sb.slot_time[$urandom_range(0, sb.fill - 1)]
                             + $urandom_range(0, 2) - 1;
        else t = $urandom_range(0, 63);
      end
      default: t = $urandom;
    endcase
    return t;
  endfunction

  task automatic random_request(input logic [1:0] kind, input logic [TIME_BITS-1:0] ts);
    send_request(kind, ts, 16'($urandom));
    if (kind != KIND_UNUSED) random_sent++;
    quiet = (random_sent >= 150 && random_sent < 260);
    maybe_idle();
  endtask

  task automatic fill_burst();
    while (sb.fill < QUEUE_DEPTH) random_request(KIND_INSERT, pick_time());
    repeat ($urandom_range(1, 2)) random_request(KIND_INSERT, pick_time());
  endtask

  initial begin
    int unsigned roll;
    sb            = new();
    random_sent   = 0;
    quiet         = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_kind       = KIND_INSERT;
    in_time_stamp = '0;
    in_payload    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queue, none due, equal times, extreme times, unused kind
    send_request(KIND_POP,     '0,           '0);
    send_request(KIND_RELEASE, '0,           '0);
    send_request(KIND_INSERT,  32'd100,      16'h1111);
    send_request(KIND_INSERT,  32'd100,      16'h2222);
    send_request(KIND_INSERT,  '1,           '1);
    send_request(KIND_RELEASE, 32'd99,       16'hFFFF);
    send_request(KIND_INSERT,  '0,           '0);
    send_request(KIND_INSERT,  32'd50,       16'hA5A5);
    send_request(KIND_INSERT,  32'h8000_0000, 16'h5A5A);
    send_request(KIND_POP,     '1,           '1);
    send_request(KIND_RELEASE, 32'd100,      '0);
    send_request(KIND_RELEASE, 32'hFFFF_FFFE, '0);
    send_request(KIND_UNUSED,  '1,           '1);
    send_request(KIND_RELEASE, '1,           '0);
    send_request(KIND_POP,     '0,           '0);
    send_request(KIND_RELEASE, '1,           '1);
    drain_results();

    // random: start from a full queue, then mixed traffic
    fill_burst();
    random_request(KIND_RELEASE, '1);
    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)      random_request(KIND_INSERT, pick_time());
      else if (roll < 60) random_request(KIND_POP, pick_time());
      else if (roll < 82) random_request(KIND_RELEASE, pick_time());
      else if (roll < 86) fill_burst();
      else if (roll < 93) random_request(KIND_RELEASE, '1);
      else if (roll < 97) random_request(KIND_UNUSED, $urandom);
      else                drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d results: %0d full drops, %0d empty or none due,",
             sb.requests_seen, sb.results_seen, sb.full_drops, sb.empty_hits);
    $display("longest release %0d entries, %0d field errors or stray results.",
             sb.longest_release, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tseq_pkg.sv
rtl/tseq_ctrl.sv
rtl/tseq_datapath.sv
rtl/time_sorted_event_queue.sv
rtl/tseq_checker.sv
tb/sv/tb_top.sv
